// ===== rtl/stack_queue_engine_core_defines.svh =====
// Assertion macros used by the stack/queue engine datapath.
`ifndef STACK_QUEUE_ENGINE_CORE_DEFINES_SVH
`define STACK_QUEUE_ENGINE_CORE_DEFINES_SVH

// Condition holds at every clock edge out of reset.
`define SQE_ASSERT_HOLDS(label, cond, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (cond)) \
      else $error(msg);

// Consequence holds in the cycle after the antecedent.
`define SQE_ASSERT_NEXT(label, ante, cons, msg) \
   label: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

// ===== rtl/sqe_pkg.sv =====
// Shared constants, types and helpers of the stack/queue engine.
`default_nettype none

package sqe_pkg;

   localparam int DEPTH    = 64;
   localparam int ADDR_W   = (DEPTH > 1) ? $clog2(DEPTH) : 1;
   localparam int CNT_W    = $clog2(DEPTH + 1);
   localparam int DATA_W   = 32;
   localparam int OP_W     = 3;
   localparam int STATUS_W = 2;

   localparam logic [CNT_W-1:0]  FULL_COUNT = CNT_W'(DEPTH);
   localparam logic [ADDR_W:0]   DEPTH_WRAP = (ADDR_W + 1)'(DEPTH);
   localparam logic [ADDR_W-1:0] ADDR_BACK  = ADDR_W'(DEPTH - 1);
   localparam logic [ADDR_W-1:0] ADDR_ONE   = ADDR_W'(1);

   localparam logic [OP_W-1:0] OP_PUSH = 3'd0;
   localparam logic [OP_W-1:0] OP_POP  = 3'd1;
   localparam logic [OP_W-1:0] OP_PEEK = 3'd2;
   localparam logic [OP_W-1:0] OP_SWAP = 3'd3;
   localparam logic [OP_W-1:0] OP_LIST = 3'd4;

   typedef enum logic [STATUS_W-1:0] {
      ST_OK    = 2'd0,
      ST_EMPTY = 2'd1,
      ST_SHORT = 2'd2,
      ST_FULL  = 2'd3
   } status_type;

   typedef enum logic [1:0] {
      ADDR_TOP       = 2'd0,
      ADDR_NEXT      = 2'd1,
      ADDR_WALK_NEXT = 2'd2,
      ADDR_PUSH      = 2'd3
   } addr_sel_type;

   typedef enum logic [1:0] {
      WD_PUSH = 2'd0,
      WD_READ = 2'd1,
      WD_HOLD = 2'd2
   } wd_sel_type;

   typedef struct packed {
      logic         mem_re;
      logic         mem_we;
      addr_sel_type addr_sel;
      wd_sel_type   wd_sel;
      logic         push_commit;
      logic         pop_commit;
      logic         hold_load;
      logic         walk_clr;
      logic         walk_inc;
      logic         out_load;
      logic         out_from_mem;
      logic         out_last;
      logic         code_load;
      status_type   code;
   } cmd_type;

   typedef struct packed {
      logic empty;
      logic full;
      logic short_count;
      logic out_free;
      logic walk_last;
   } sts_type;

   // Ring slot base + off, both below DEPTH.
   function automatic logic [ADDR_W-1:0] slot_add(input logic [ADDR_W-1:0] base,
                                                  input logic [ADDR_W-1:0] off);
      logic [ADDR_W:0] sum;
      sum = {1'b0, base} + {1'b0, off};
      if (sum >= DEPTH_WRAP) begin
         sum = sum - DEPTH_WRAP;
      end
      return sum[ADDR_W-1:0];
   endfunction

endpackage

`default_nettype wire

// ===== rtl/sqe_ctrl.sv =====
// Controller state machine of the stack/queue engine.
`default_nettype none

module sqe_ctrl (
   input  wire logic                     clock,
   input  wire logic                     reset,
   input  wire logic                     req_valid,
   output logic                          req_ready,
   input  wire logic [sqe_pkg::OP_W-1:0] req_operation,
   input  wire sqe_pkg::sts_type         sts,
   output sqe_pkg::cmd_type              cmd
);

   typedef enum logic [6:0] {
      S_IDLE        = 7'b0000001,
      S_RESULT_CODE = 7'b0000010,
      S_RESULT_MEM  = 7'b0000100,
      S_SWAP_RD_B   = 7'b0001000,
      S_SWAP_WR_A   = 7'b0010000,
      S_SWAP_WR_B   = 7'b0100000,
      S_LIST_OUT    = 7'b1000000
   } state_type;

   state_type state_ff, state_in;
   logic      is_pop_ff, is_pop_in;

   assign req_ready = (state_ff == S_IDLE);

   always_comb begin
      cmd       = '0;
      state_in  = state_ff;
      is_pop_in = is_pop_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               unique case (req_operation) inside
                  sqe_pkg::OP_PUSH: begin
                     cmd.code_load = 1'b1;
                     state_in      = S_RESULT_CODE;
                     if (sts.full) begin
                        cmd.code = sqe_pkg::ST_FULL;
                     end else begin
                        cmd.code        = sqe_pkg::ST_OK;
                        cmd.mem_we      = 1'b1;
                        cmd.addr_sel    = sqe_pkg::ADDR_PUSH;
                        cmd.wd_sel      = sqe_pkg::WD_PUSH;
                        cmd.push_commit = 1'b1;
                     end
                  end
                  sqe_pkg::OP_POP, sqe_pkg::OP_PEEK: begin
                     if (sts.empty) begin
                        cmd.code_load = 1'b1;
                        cmd.code      = sqe_pkg::ST_EMPTY;
                        state_in      = S_RESULT_CODE;
                     end else begin
                        cmd.mem_re   = 1'b1;
                        cmd.addr_sel = sqe_pkg::ADDR_TOP;
                        is_pop_in    = (req_operation == sqe_pkg::OP_POP);
                        state_in     = S_RESULT_MEM;
                     end
                  end
                  sqe_pkg::OP_SWAP: begin
                     if (sts.short_count) begin
                        cmd.code_load = 1'b1;
                        cmd.code      = sqe_pkg::ST_SHORT;
                        state_in      = S_RESULT_CODE;
                     end else begin
                        cmd.mem_re   = 1'b1;
                        cmd.addr_sel = sqe_pkg::ADDR_TOP;
                        state_in     = S_SWAP_RD_B;
                     end
                  end
                  sqe_pkg::OP_LIST: begin
                     if (sts.empty) begin
                        cmd.code_load = 1'b1;
                        cmd.code      = sqe_pkg::ST_EMPTY;
                        state_in      = S_RESULT_CODE;
                     end else begin
                        cmd.mem_re   = 1'b1;
                        cmd.addr_sel = sqe_pkg::ADDR_TOP;
                        cmd.walk_clr = 1'b1;
                        state_in     = S_LIST_OUT;
                     end
                  end
                  default: begin
                     // drop unknown operations
                     state_in = S_IDLE;
                  end
               endcase
            end
         end
         S_RESULT_CODE: begin
            if (sts.out_free) begin
               cmd.out_load = 1'b1;
               state_in     = S_IDLE;
            end
         end
         S_RESULT_MEM: begin
            if (sts.out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_from_mem = 1'b1;
               cmd.out_last     = 1'b1;
               cmd.pop_commit   = is_pop_ff;
               state_in         = S_IDLE;
            end
         end
         S_SWAP_RD_B: begin
            // keep the top value while the second one is read
            cmd.hold_load = 1'b1;
            cmd.mem_re    = 1'b1;
            cmd.addr_sel  = sqe_pkg::ADDR_NEXT;
            state_in      = S_SWAP_WR_A;
         end
         S_SWAP_WR_A: begin
            cmd.mem_we   = 1'b1;
            cmd.addr_sel = sqe_pkg::ADDR_TOP;
            cmd.wd_sel   = sqe_pkg::WD_READ;
            state_in     = S_SWAP_WR_B;
         end
         S_SWAP_WR_B: begin
            cmd.mem_we    = 1'b1;
            cmd.addr_sel  = sqe_pkg::ADDR_NEXT;
            cmd.wd_sel    = sqe_pkg::WD_HOLD;
            cmd.code_load = 1'b1;
            cmd.code      = sqe_pkg::ST_OK;
            state_in      = S_RESULT_CODE;
         end
         S_LIST_OUT: begin
            if (sts.out_free) begin
               cmd.out_load     = 1'b1;
               cmd.out_from_mem = 1'b1;
               cmd.out_last     = sts.walk_last;
               if (sts.walk_last) begin
                  state_in = S_IDLE;
               end else begin
                  // fetch the next entry while this one is handed off
                  cmd.mem_re   = 1'b1;
                  cmd.addr_sel = sqe_pkg::ADDR_WALK_NEXT;
                  cmd.walk_inc = 1'b1;
               end
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff  <= S_IDLE;
         is_pop_ff <= 1'b0;
      end else begin
         state_ff  <= state_in;
         is_pop_ff <= is_pop_in;
      end
   end

endmodule

`default_nettype wire

// ===== rtl/sqe_dpath.sv =====
// Datapath of the stack/queue engine: ring memory, pointers and result register.
`default_nettype none
`include "stack_queue_engine_core_defines.svh"

module sqe_dpath (
   input  wire logic                               clock,
   input  wire logic                               reset,
   input  wire sqe_pkg::cmd_type                   cmd,
   output sqe_pkg::sts_type                        sts,
   input  wire logic signed [sqe_pkg::DATA_W-1:0]  req_push_value,
   input  wire logic                               csr_valid,
   output logic                                    csr_ready,
   input  wire logic                               csr_queue_mode,
   output logic                                    rsp_valid,
   input  wire logic                               rsp_ready,
   output logic signed [sqe_pkg::DATA_W-1:0]       rsp_data,
   output logic        [sqe_pkg::STATUS_W-1:0]     rsp_status,
   output logic                                    rsp_last
);

   logic [sqe_pkg::DATA_W-1:0] mem [sqe_pkg::DEPTH];

   logic [sqe_pkg::ADDR_W-1:0] top_ff, top_in;
   logic [sqe_pkg::CNT_W-1:0]  count_ff, count_in;
   logic [sqe_pkg::ADDR_W-1:0] walk_ff, walk_in;
   logic                       mode_ff;
   logic [sqe_pkg::DATA_W-1:0] rd_data_ff;
   logic [sqe_pkg::DATA_W-1:0] hold_ff;
   sqe_pkg::status_type        code_ff;
   logic                       out_valid_ff;
   logic [sqe_pkg::DATA_W-1:0] out_data_ff;
   sqe_pkg::status_type        out_status_ff;
   logic                       out_last_ff;

   logic [sqe_pkg::ADDR_W-1:0] addr;
   logic [sqe_pkg::ADDR_W-1:0] push_addr;
   logic [sqe_pkg::ADDR_W-1:0] next_addr;
   logic [sqe_pkg::ADDR_W-1:0] walk_next;
   logic [sqe_pkg::DATA_W-1:0] wr_data;

   assign next_addr = sqe_pkg::slot_add(top_ff, sqe_pkg::ADDR_ONE);
   assign walk_next = walk_ff + 1'b1;

   always_comb begin
      if (count_ff == '0) begin
         push_addr = top_ff;
      end else if (!mode_ff) begin
         push_addr = sqe_pkg::slot_add(top_ff, sqe_pkg::ADDR_BACK);
      end else begin
         push_addr = sqe_pkg::slot_add(top_ff, count_ff[sqe_pkg::ADDR_W-1:0]);
      end
   end

   always_comb begin
      unique case (cmd.addr_sel)
         sqe_pkg::ADDR_TOP:       addr = top_ff;
         sqe_pkg::ADDR_NEXT:      addr = next_addr;
         sqe_pkg::ADDR_WALK_NEXT: addr = sqe_pkg::slot_add(top_ff, walk_next);
         sqe_pkg::ADDR_PUSH:      addr = push_addr;
         default:                 addr = top_ff;
      endcase
   end

   always_comb begin
      unique case (cmd.wd_sel)
         sqe_pkg::WD_PUSH: wr_data = req_push_value;
         sqe_pkg::WD_READ: wr_data = rd_data_ff;
         sqe_pkg::WD_HOLD: wr_data = hold_ff;
         default:          wr_data = req_push_value;
      endcase
   end

   always_ff @(posedge clock) begin
      if (cmd.mem_we) begin
         mem[addr] <= wr_data;
      end
      if (cmd.mem_re) begin
         rd_data_ff <= mem[addr];
      end
   end

   always_comb begin
      top_in   = top_ff;
      count_in = count_ff;
      if (cmd.push_commit) begin
         count_in = count_ff + 1'b1;
         if ((count_ff != '0) && !mode_ff) begin
            top_in = push_addr;
         end
      end else if (cmd.pop_commit) begin
         count_in = count_ff - 1'b1;
         top_in   = next_addr;
      end
   end

   always_comb begin
      walk_in = walk_ff;
      if (cmd.walk_clr) begin
         walk_in = '0;
      end else if (cmd.walk_inc) begin
         walk_in = walk_next;
      end
   end

   assign csr_ready = 1'b1;

   always_ff @(posedge clock) begin
      if (reset) begin
         top_ff       <= '0;
         count_ff     <= '0;
         walk_ff      <= '0;
         mode_ff      <= 1'b0;
         out_valid_ff <= 1'b0;
      end else begin
         top_ff   <= top_in;
         count_ff <= count_in;
         walk_ff  <= walk_in;
         if (csr_valid) begin
            mode_ff <= csr_queue_mode;
         end
         if (cmd.out_load) begin
            out_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            out_valid_ff <= 1'b0;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.hold_load) begin
         hold_ff <= rd_data_ff;
      end
      if (cmd.code_load) begin
         code_ff <= cmd.code;
      end
      if (cmd.out_load) begin
         if (cmd.out_from_mem) begin
            out_data_ff   <= rd_data_ff;
            out_status_ff <= sqe_pkg::ST_OK;
            out_last_ff   <= cmd.out_last;
         end else begin
            out_data_ff   <= '0;
            out_status_ff <= code_ff;
            out_last_ff   <= 1'b1;
         end
      end
   end

   assign sts.empty       = (count_ff == '0);
   assign sts.full        = (count_ff >= sqe_pkg::FULL_COUNT);
   assign sts.short_count = (count_ff < sqe_pkg::CNT_W'(2));
   assign sts.out_free    = !out_valid_ff || rsp_ready;
   assign sts.walk_last   = ({1'b0, walk_ff} + 1'b1 == {1'b0, count_ff});

   assign rsp_valid  = out_valid_ff;
   assign rsp_data   = out_data_ff;
   assign rsp_status = out_status_ff;
   assign rsp_last   = out_last_ff;

   `SQE_ASSERT_HOLDS(a_count_bound, count_ff <= sqe_pkg::FULL_COUNT, "entry count beyond depth")
   `SQE_ASSERT_HOLDS(a_single_port, !(cmd.mem_we && cmd.mem_re), "two ring accesses in one cycle")
   `SQE_ASSERT_HOLDS(a_pop_nonempty, !cmd.pop_commit || (count_ff != '0), "pop on empty ring")
   `SQE_ASSERT_NEXT(a_push_grows, cmd.push_commit, count_ff == $past(count_ff) + 1'b1, "push lost")

endmodule

`default_nettype wire

// ===== rtl/stack_queue_engine_core.sv =====
// Top level of the stack/queue engine: controller plus datapath.
//
// Bounded ring of signed 32-bit values with push, pop, peek, swap-top-two
// and list-all. Requests enter on req_valid/req_ready (req_operation,
// req_push_value); results leave on rsp_valid/rsp_ready (rsp_data,
// rsp_status, rsp_last). csr_valid/csr_ready writes csr_queue_mode:
// 0 pushes at the top, 1 appends at the bottom. Write it only when idle.
// One request is in work at a time; req_ready is high in the idle state.
// Swap passes through S_SWAP_RD_B, S_SWAP_WR_A and S_SWAP_WR_B (one
// ring port: two reads, two writes). List-all gives one entry per cycle
// while the receiver is ready, count entries, the final one marked by
// rsp_last. Unknown operations give no result.
// A held result sits in the output register; a stalled receiver holds
// the controller in its result state until the transfer.
// Reset empties the store and selects stack mode; ring contents stay
// undefined and are never read before they are written.
`default_nettype none

module stack_queue_engine_core (
   input  wire logic                                 clock,
   input  wire logic                                 reset,
   input  wire logic                                 req_valid,
   output logic                                      req_ready,
   input  wire logic        [sqe_pkg::OP_W-1:0]      req_operation,
   input  wire logic signed [sqe_pkg::DATA_W-1:0]    req_push_value,
   output logic                                      rsp_valid,
   input  wire logic                                 rsp_ready,
   output logic signed      [sqe_pkg::DATA_W-1:0]    rsp_data,
   output logic             [sqe_pkg::STATUS_W-1:0]  rsp_status,
   output logic                                      rsp_last,
   input  wire logic                                 csr_valid,
   output logic                                      csr_ready,
   input  wire logic                                 csr_queue_mode
);

   sqe_pkg::cmd_type cmd;
   sqe_pkg::sts_type sts;

   sqe_ctrl u_ctrl (
      .clock         (clock),
      .reset         (reset),
      .req_valid     (req_valid),
      .req_ready     (req_ready),
      .req_operation (req_operation),
      .sts           (sts),
      .cmd           (cmd)
   );

   sqe_dpath u_dpath (
      .clock          (clock),
      .reset          (reset),
      .cmd            (cmd),
      .sts            (sts),
      .req_push_value (req_push_value),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_queue_mode (csr_queue_mode),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last)
   );

endmodule

`default_nettype wire

// ===== tb/sv/sqe_result_checker.sv =====
// Result checker for the stack/queue engine: tracks the ring and compares every result.
module sqe_result_checker
   import sqe_pkg::*;
(
   input  logic                       clock,
   input  logic                       reset,
   input  logic                       req_valid,
   input  logic                       req_ready,
   input  logic [OP_W-1:0]            req_operation,
   input  logic signed [DATA_W-1:0]   req_push_value,
   input  logic                       rsp_valid,
   input  logic                       rsp_ready,
   input  logic signed [DATA_W-1:0]   rsp_data,
   input  logic [STATUS_W-1:0]        rsp_status,
   input  logic                       rsp_last,
   input  logic                       csr_valid,
   input  logic                       csr_ready,
   input  logic                       csr_queue_mode,
   output int                         outstanding,
   output int                         fail_count
);

   typedef struct packed {
      logic signed [DATA_W-1:0] data;
      status_type               status;
      logic                     last;
   } result_type;

   logic signed [DATA_W-1:0] ring [DEPTH];
   logic [ADDR_W-1:0]        top_slot = '0;
   logic [CNT_W-1:0]         entry_count = '0;
   logic                     queue_mode = 1'b0;
   result_type               expected_q [$];
   int                       mismatches = 0;
   int                       results_seen = 0;

   function automatic logic [ADDR_W-1:0] slot_at(input int offset);
      return ADDR_W'((int'(top_slot) + offset) % DEPTH);
   endfunction

   task automatic report_mismatch(input string what, input logic signed [DATA_W-1:0] want,
                                  input logic signed [DATA_W-1:0] got);
      $display("result %0d: %s expected %0d, got %0d", results_seen, what, want, got);
      mismatches++;
   endtask

   task automatic add_expected(input logic signed [DATA_W-1:0] data, input status_type status,
                               input logic last);
      result_type r;
      r.data = data;
      r.status = status;
      r.last = last;
      expected_q.push_back(r);
   endtask

   task automatic predict_request(input logic [OP_W-1:0] op,
                                  input logic signed [DATA_W-1:0] value);
      logic [ADDR_W-1:0]        next_slot;
      logic signed [DATA_W-1:0] held;
      case (op)
         OP_PUSH: begin
            if (entry_count == FULL_COUNT) begin
               add_expected('0, ST_FULL, 1'b1);
            end else begin
               if (entry_count == 0) begin
                  ring[top_slot] = value;
               end else if (!queue_mode) begin
                  top_slot = slot_at(DEPTH - 1);
                  ring[top_slot] = value;
               end else begin
                  ring[slot_at(int'(entry_count))] = value;
               end
               entry_count++;
               add_expected('0, ST_OK, 1'b1);
            end
         end
         OP_POP: begin
            if (entry_count == 0) begin
               add_expected('0, ST_EMPTY, 1'b1);
            end else begin
               held = ring[top_slot];
               top_slot = slot_at(1);
               entry_count--;
               add_expected(held, ST_OK, 1'b1);
            end
         end
         OP_PEEK: begin
            if (entry_count == 0) begin
               add_expected('0, ST_EMPTY, 1'b1);
            end else begin
               add_expected(ring[top_slot], ST_OK, 1'b1);
            end
         end
         OP_SWAP: begin
            if (entry_count < 2) begin
               add_expected('0, ST_SHORT, 1'b1);
            end else begin
               next_slot = slot_at(1);
               held = ring[top_slot];
               ring[top_slot] = ring[next_slot];
               ring[next_slot] = held;
               add_expected('0, ST_OK, 1'b1);
            end
         end
         OP_LIST: begin
            if (entry_count == 0) begin
               add_expected('0, ST_EMPTY, 1'b1);
            end else begin
               for (int i = 0; i < int'(entry_count); i++) begin
                  add_expected(ring[slot_at(i)], ST_OK, i == int'(entry_count) - 1);
               end
            end
         end
         default: begin
            // drop: reserved operations leave no trace
         end
      endcase
   endtask

   task automatic check_result();
      result_type want;
      results_seen++;
      if (expected_q.size() == 0) begin
         report_mismatch("unexpected result, data", '0, rsp_data);
      end else begin
         want = expected_q.pop_front();
         if (rsp_data !== want.data) begin
            report_mismatch("data", want.data, rsp_data);
         end
         if (rsp_status !== want.status) begin
            report_mismatch("status", DATA_W'(want.status), DATA_W'(rsp_status));
         end
         if (rsp_last !== want.last) begin
            report_mismatch("last", DATA_W'(want.last), DATA_W'(rsp_last));
         end
      end
   endtask

   always @(posedge clock) begin
      if (reset) begin
         top_slot = '0;
         entry_count = '0;
         queue_mode = 1'b0;
         expected_q.delete();
      end else begin
         if (csr_valid && csr_ready) begin
            queue_mode = csr_queue_mode;
         end
         if (rsp_valid && rsp_ready) begin
            check_result();
         end
         if (req_valid && req_ready) begin
            predict_request(req_operation, req_push_value);
         end
      end
      outstanding <= expected_q.size();
      fail_count <= mismatches;
   end

endmodule

// ===== tb/sv/tb.sv =====
// Testbench top for the stack/queue engine: stimulus, receiver stalls and verdict.
module tb;
   import sqe_pkg::*;

   localparam int                        TIMEOUT_CYCLES = 2_000_000;
   localparam int                        STALL_CYCLES   = 400;
   localparam int                        SETTLE_CYCLES  = 8;
   localparam int                        DRAIN_LIMIT    = 100_000;
   localparam logic                      MODE_STACK     = 1'b0;
   localparam logic                      MODE_QUEUE     = 1'b1;
   localparam logic [OP_W-1:0]           OP_RESERVED_LO = 3'd5;
   localparam logic [OP_W-1:0]           OP_RESERVED_HI = 3'd7;
   localparam logic signed [DATA_W-1:0]  VALUE_MAX = {1'b0, {(DATA_W-1){1'b1}}};
   localparam logic signed [DATA_W-1:0]  VALUE_MIN = {1'b1, {(DATA_W-1){1'b0}}};

   logic                       clock = 1'b0;
   logic                       reset = 1'b1;
   logic                       req_valid = 1'b0;
   logic                       req_ready;
   logic [OP_W-1:0]            req_operation = '0;
   logic signed [DATA_W-1:0]   req_push_value = '0;
   logic                       rsp_valid;
   logic                       rsp_ready = 1'b0;
   logic signed [DATA_W-1:0]   rsp_data;
   logic [STATUS_W-1:0]        rsp_status;
   logic                       rsp_last;
   logic                       csr_valid = 1'b0;
   logic                       csr_ready;
   logic                       csr_queue_mode = 1'b0;

   int outstanding;
   int fail_count;
   int tx_idle_pct = 19;
   int rx_idle_pct = 75;
   int stall_requests = 0;
   int stall_seen = 0;
   int stall_left = 0;

   always #4 clock = ~clock;

   stack_queue_engine_core DUT (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_queue_mode (csr_queue_mode)
   );

   sqe_result_checker result_checker (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_ready      (req_ready),
      .req_operation  (req_operation),
      .req_push_value (req_push_value),
      .rsp_valid      (rsp_valid),
      .rsp_ready      (rsp_ready),
      .rsp_data       (rsp_data),
      .rsp_status     (rsp_status),
      .rsp_last       (rsp_last),
      .csr_valid      (csr_valid),
      .csr_ready      (csr_ready),
      .csr_queue_mode (csr_queue_mode),
      .outstanding    (outstanding),
      .fail_count     (fail_count)
   );

   // Receiver: random backpressure, or a long hold-off when one is requested.
   always @(posedge clock) begin
      if (stall_requests != stall_seen) begin
         stall_seen = stall_requests;
         stall_left = STALL_CYCLES;
      end
      if (stall_left > 0) begin
         stall_left--;
         rsp_ready <= 1'b0;
      end else begin
         rsp_ready <= ($urandom_range(99) >= rx_idle_pct);
      end
   end

   task automatic send_request(input logic [OP_W-1:0] op, input logic signed [DATA_W-1:0] value);
      while ($urandom_range(99) < tx_idle_pct) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      req_valid <= 1'b1;
      req_operation <= op;
      req_push_value <= value;
      @(posedge clock);
      while (!req_ready) begin
         @(posedge clock);
      end
   endtask

   task automatic write_queue_mode(input logic mode);
      csr_valid <= 1'b1;
      csr_queue_mode <= mode;
      @(posedge clock);
      while (!csr_ready) begin
         @(posedge clock);
      end
      csr_valid <= 1'b0;
   endtask

   // Drop valid, wait for every expected result, then let reserved ops retire.
   task automatic wait_idle();
      int waited;
      waited = 0;
      req_valid <= 1'b0;
      do begin
         @(posedge clock);
         waited++;
      end while (outstanding != 0 && waited < DRAIN_LIMIT);
      repeat (SETTLE_CYCLES) @(posedge clock);
   endtask

   function automatic logic signed [DATA_W-1:0] random_value();
      case ($urandom_range(9))
         0:       return VALUE_MAX;
         1:       return VALUE_MIN;
         2:       return $urandom_range(1) ? '0 : '1;
         default: return $urandom;
      endcase
   endfunction

   function automatic logic [OP_W-1:0] pick_reserved_op(input int pick);
      return (pick == 0) ? OP_RESERVED_LO : (pick == 1) ? OP_RESERVED_LO + 3'd1 : OP_RESERVED_HI;
   endfunction

   // Alternate fill and drain runs so the store reaches full and empty often.
   task automatic run_random(input int count);
      int              sent;
      int              run_left;
      int              pick;
      bit              filling;
      logic [OP_W-1:0] op;
      sent = 0;
      filling = 1'b1;
      run_left = $urandom_range(110, 60);
      while (sent < count) begin
         if (run_left == 0) begin
            filling = !filling;
            run_left = filling ? $urandom_range(110, 60) : $urandom_range(90, 30);
         end
         run_left--;
         pick = $urandom_range(99);
         if (pick < 3) begin
            op = pick_reserved_op(pick);
         end else if (filling) begin
            op = (pick < 80) ? OP_PUSH : (pick < 86) ? OP_POP : (pick < 91) ? OP_PEEK :
                 (pick < 96) ? OP_SWAP : OP_LIST;
         end else begin
            op = (pick < 25) ? OP_PUSH : (pick < 70) ? OP_POP : (pick < 80) ? OP_PEEK :
                 (pick < 90) ? OP_SWAP : OP_LIST;
         end
         send_request(op, random_value());
         if (op <= OP_LIST) begin
            sent++;
         end
      end
   endtask

   initial begin
      repeat (9) @(posedge clock);
      reset <= 1'b0;
      write_queue_mode(MODE_STACK);

      // stack mode: errors on an empty store, then a two-entry store
      send_request(OP_POP, random_value());
      send_request(OP_PEEK, random_value());
      send_request(OP_SWAP, random_value());
      send_request(OP_LIST, random_value());
      send_request(OP_PUSH, VALUE_MAX);
      send_request(OP_SWAP, random_value());
      send_request(OP_PUSH, VALUE_MIN);
      send_request(OP_PEEK, random_value());
      send_request(OP_SWAP, random_value());
      send_request(OP_LIST, random_value());
      send_request(OP_RESERVED_LO, random_value());
      send_request(OP_RESERVED_HI, random_value());
      send_request(OP_POP, random_value());
      send_request(OP_POP, random_value());
      send_request(OP_POP, random_value());
      wait_idle();

      // queue mode: first push lands on the top slot, later ones below
      write_queue_mode(MODE_QUEUE);
      send_request(OP_PUSH, '0);
      send_request(OP_PUSH, '1);
      send_request(OP_PUSH, DATA_W'(1));
      send_request(OP_LIST, random_value());
      send_request(OP_SWAP, random_value());
      send_request(OP_PEEK, random_value());
      send_request(OP_POP, random_value());
      send_request(OP_LIST, random_value());
      run_random(150);
      wait_idle();

      tx_idle_pct = 75;
      rx_idle_pct <= 19;
      write_queue_mode(MODE_STACK);
      run_random(150);
      wait_idle();

      tx_idle_pct = 0;
      rx_idle_pct <= 0;
      write_queue_mode(MODE_QUEUE);
      // hold the receiver off while requests keep coming
      stall_requests <= stall_requests + 1;
      run_random(150);
      wait_idle();

      if (outstanding != 0) begin
         $display("%0d expected results never arrived", outstanding);
      end
      if (fail_count == 0 && outstanding == 0) begin
         $display("CHECK OK");
      end else begin
         $display("CHECK FAILED");
      end
      $finish;
   end

   initial begin
      #(TIMEOUT_CYCLES * 8);
      $display("CHECK FAILED");
      $finish;
   end

endmodule
